@@ design/scsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsi_pkg: shared types and constants of the skin conductance stress index
// Sequencer states, action and register codes, score constants and the
// default sizes of the history, peak window, amplitude store and lookback.
// ----------------------------------------------------------------------------
package scsi_pkg;

	// default sizes
	localparam int HISTORY_DEPTH_DEF   = 60;
	localparam int PEAK_WINDOW_DEF     = 60;
	localparam int AMPLITUDE_SLOTS_DEF = 10;
	localparam int LOOKBACK_DEF        = 5;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 1'b1;
	localparam logic [14:0] PEAK_THRESHOLD_RST = 15'd30;
	localparam logic [15:0] MIN_INTERVAL_RST   = 16'd500;

	// input action codes
	localparam logic ACT_PROCESS = 1'b0;
	localparam logic ACT_CLEAR   = 1'b1;

	// stream widths
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 96;

	// baseline average: floor((19*b + x) / 20)
	localparam int BASE_NUM_W = 21;
	localparam logic [BASE_NUM_W-1:0] BASE_OLD_WEIGHT = 21'd19;
	localparam logic [4:0]            BASE_DIVISOR    = 5'd20;
	localparam int BASE_DVS_W = 5;

	// phasic saturation and peak count saturation
	localparam logic [15:0] PHASIC_MAX     = 16'd32767;
	localparam logic [6:0]  PEAK_COUNT_MAX = 7'd63;
	localparam int          READY_SAMPLES  = 10;

	// score terms
	localparam logic [6:0]  SCORE_MAX  = 7'd100;
	localparam logic [5:0]  FREQ_FULL  = 6'd10;
	localparam logic [6:0]  FREQ_STEP  = 7'd10;
	localparam logic [15:0] AMP_FULL   = 16'd500;
	localparam logic [15:0] BASE_HIGH  = 16'd2000;
	localparam logic [15:0] BASE_LOW   = 16'd1000;
	localparam logic [13:0] FREQ_WEIGHT = 14'd60;
	localparam logic [13:0] AMP_WEIGHT  = 14'd30;
	localparam logic [13:0] BASE_WEIGHT = 14'd10;
	// reciprocals: x/5 = x*205 >> 10 (x <= 500), x/10 = x*205 >> 11 (x <= 1000),
	// x/100 = x*5243 >> 19 (x <= 10000)
	localparam logic [16:0] RECIP_5   = 17'd205;
	localparam logic [17:0] RECIP_10  = 18'd205;
	localparam logic [26:0] RECIP_100 = 27'd5243;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEED,
		ST_BDIV,
		ST_EVAL,
		ST_MDIV,
		ST_MEAN,
		ST_SCORE,
		ST_WEIGH,
		ST_DONE
	} state_t;

endpackage

@@ design/skin_conductance_stress_index.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_conductance_stress_index: stress score from skin conductance samples
// Baseline tracking, peak detection over a lookback, peak window and
// amplitude store, and a weighted 0..100 score, under a small sequencer
// around one shared serial divider.
// ----------------------------------------------------------------------------
// One word in, one word out. A clear word or the first sample after reset or
// clear goes from acceptance through the clear or seed state to the result.
// Any other sample runs the baseline average through the serial divider (one
// quotient bit a cycle), then, when any peak amplitude is stored, the mean
// amplitude through the same divider again. s_tready is high only while the
// sequencer is idle; a finished result waits in the output register and does
// not hold off the next input word.
module skin_conductance_stress_index #(
	parameter int HISTORY_DEPTH   = scsi_pkg::HISTORY_DEPTH_DEF,
	parameter int PEAK_WINDOW     = scsi_pkg::PEAK_WINDOW_DEF,
	parameter int AMPLITUDE_SLOTS = scsi_pkg::AMPLITUDE_SLOTS_DEF,
	parameter int LOOKBACK        = scsi_pkg::LOOKBACK_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [scsi_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [scsi_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [scsi_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// gsr_value [15:0], timestamp_ms [47:16]
	input  logic [scsi_pkg::IN_DATA_W-1:0]  s_tdata,
	// action [0]
	input  logic                            s_tuser,
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// stress_level [6:0], tonic_level [22:7], phasic_level [37:23],
	// peak_count [43:38], mean_peak_amplitude [58:44], last_peak_stamp [90:59]
	output logic [scsi_pkg::OUT_DATA_W-1:0] m_tdata,
	// data_ready [0]
	output logic                            m_tuser
);
	import scsi_pkg::*;

	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int PC_W    = $clog2(PEAK_WINDOW + 1);
	localparam int SLOT_W  = (AMPLITUDE_SLOTS > 1) ? $clog2(AMPLITUDE_SLOTS) : 1;
	localparam int ACNT_W  = $clog2(AMPLITUDE_SLOTS + 1);
	localparam int SUM_W   = 15 + ACNT_W;
	localparam int DVS_W   = (ACNT_W > BASE_DVS_W) ? ACNT_W : BASE_DVS_W;
	localparam int DIV_W   = (SUM_W > BASE_NUM_W) ? SUM_W : BASE_NUM_W;
	localparam int DCNT_W  = $clog2(DIV_W);

	// configuration registers
	logic [14:0] thr_q;
	logic [15:0] ivl_q;
	logic        cfg_wr;
	logic [CFG_IDX_W-1:0] cfg_idx;

	// sequencer
	state_t state_q, state_n;
	logic   in_acc, load_base, load_mean, div_run, out_load;

	// input word
	logic [15:0] x_q;
	logic [31:0] t_q;

	// detector state
	logic [15:0]       baseline_q;
	logic              base_valid_q;
	logic [15:0]       recent_q [LOOKBACK];
	logic [CNT_W-1:0]  scount_q;
	logic [PEAK_WINDOW-1:0] win_q;
	logic [PC_W-1:0]   pcnt_q;
	logic [14:0]       amp_q [AMPLITUDE_SLOTS];
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  amp_sum_q;
	logic [ACNT_W-1:0] amp_cnt_q;
	logic [31:0]       last_q;
	logic [14:0]       mean_q;

	// per-sample results
	logic [14:0] phasic_q;
	logic        ready_q;
	logic [6:0]  fs_q, as_q, bs_q;
	logic [13:0] w_q;

	// shared serial divider
	logic [DIV_W-1:0]  div_quo_q;
	logic [DVS_W-1:0]  div_rem_q, div_dvs_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [DVS_W:0]    div_sh, div_sub;
	logic              div_ge;

	// evaluation datapath
	logic [BASE_NUM_W-1:0] base_num;
	logic [15:0]       b_new, diff;
	logic [14:0]       phasic;
	logic [31:0]       t_gap;
	logic              local_max, is_peak;
	logic [SLOT_W-1:0] slot_sel, slot_nxt;
	logic [14:0]       amp_old;
	logic [SUM_W-1:0]  amp_sum_n;
	logic [ACNT_W-1:0] amp_cnt_n;
	logic [CNT_W-1:0]  scount_n;

	// score datapath
	logic [6:0]  pc_ext;
	logic [5:0]  pc_out;
	logic [16:0] as_prod;
	logic [15:0] bs_diff;
	logic [17:0] bs_prod;
	logic [26:0] w_prod;
	logic [7:0]  w_div;

	// output register
	logic        m_tvalid_q;
	logic [6:0]  o_stress_q;
	logic [15:0] o_tonic_q;
	logic [14:0] o_phasic_q;
	logic [5:0]  o_pc_q;
	logic [14:0] o_mean_q;
	logic [31:0] o_stamp_q;
	logic        o_ready_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[2 +: CFG_IDX_W];

	always_comb begin
		case (cfg_idx)
			REG_PEAK_THRESHOLD: prdata = {17'd0, thr_q};
			REG_MIN_INTERVAL:   prdata = {16'd0, ivl_q};
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= PEAK_THRESHOLD_RST;
			ivl_q <= MIN_INTERVAL_RST;
		end else if (cfg_wr) begin
			if (cfg_idx == REG_PEAK_THRESHOLD)
				thr_q <= pwdata[14:0];
			if (cfg_idx == REG_MIN_INTERVAL)
				ivl_q <= pwdata[15:0];
		end
	end

	// ---------------- sequencer ----------------
	assign in_acc = s_tvalid && s_tready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser == ACT_CLEAR)
						state_n = ST_CLEAR;
					else if (!base_valid_q)
						state_n = ST_SEED;
					else
						state_n = ST_BDIV;
				end
			end
			ST_CLEAR: state_n = ST_DONE;
			ST_SEED:  state_n = ST_DONE;
			ST_BDIV: begin
				if (div_cnt_q == '0)
					state_n = ST_EVAL;
			end
			ST_EVAL:  state_n = (amp_cnt_n != '0) ? ST_MDIV : ST_SCORE;
			ST_MDIV: begin
				if (div_cnt_q == '0)
					state_n = ST_MEAN;
			end
			ST_MEAN:  state_n = ST_SCORE;
			ST_SCORE: state_n = ST_WEIGH;
			ST_WEIGH: state_n = ST_DONE;
			ST_DONE: begin
				if (out_load)
					state_n = ST_IDLE;
			end
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		load_base = (state_q == ST_IDLE) && in_acc && (s_tuser == ACT_PROCESS) && base_valid_q;
		load_mean = (state_q == ST_EVAL) && (amp_cnt_n != '0);
		div_run   = (state_q == ST_BDIV) || (state_q == ST_MDIV);
		out_load  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	// ---------------- shared divider ----------------
	assign base_num = BASE_NUM_W'(baseline_q) * BASE_OLD_WEIGHT + BASE_NUM_W'(s_tdata[15:0]);
	assign div_sh   = {div_rem_q, div_quo_q[DIV_W-1]};
	assign div_ge   = div_sh >= {1'b0, div_dvs_q};
	assign div_sub  = div_sh - {1'b0, div_dvs_q};

	always_ff @(posedge clk) begin
		if (load_base) begin
			div_quo_q <= DIV_W'(base_num);
			div_dvs_q <= DVS_W'(BASE_DIVISOR);
			div_rem_q <= '0;
			div_cnt_q <= DCNT_W'(DIV_W - 1);
		end else if (load_mean) begin
			div_quo_q <= DIV_W'(amp_sum_n);
			div_dvs_q <= DVS_W'(amp_cnt_n);
			div_rem_q <= '0;
			div_cnt_q <= DCNT_W'(DIV_W - 1);
		end else if (div_run) begin
			// shift in one quotient bit
			div_rem_q <= div_ge ? div_sub[DVS_W-1:0] : div_sh[DVS_W-1:0];
			div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// ---------------- sample evaluation ----------------
	assign b_new = div_quo_q[15:0];
	assign diff  = (x_q > b_new) ? (x_q - b_new) : 16'd0;
	assign phasic = (diff > PHASIC_MAX) ? PHASIC_MAX[14:0] : diff[14:0];
	assign t_gap = t_q - last_q;

	always_comb begin
		local_max = 1'b1;
		for (int i = 0; i < LOOKBACK; i++) begin
			if ((CNT_W'(i) < scount_q) && (x_q <= recent_q[i]))
				local_max = 1'b0;
		end
	end

	assign is_peak  = (phasic > thr_q) && (t_gap > {16'd0, ivl_q}) && local_max;
	assign slot_sel = ({1'b0, slot_q} >= (SLOT_W + 1)'(AMPLITUDE_SLOTS)) ? '0 : slot_q;
	assign slot_nxt = (slot_sel == SLOT_W'(AMPLITUDE_SLOTS - 1)) ? '0 : slot_sel + 1'b1;
	assign amp_old  = amp_q[slot_sel];

	always_comb begin
		amp_sum_n = amp_sum_q;
		amp_cnt_n = amp_cnt_q;
		if (is_peak) begin
			// replace the oldest amplitude
			amp_sum_n = amp_sum_q - SUM_W'(amp_old) + SUM_W'(phasic);
			amp_cnt_n = amp_cnt_q + ACNT_W'(amp_old == '0);
		end
	end

	assign scount_n = (scount_q < CNT_W'(HISTORY_DEPTH)) ? scount_q + 1'b1 : scount_q;

	// ---------------- score ----------------
	assign pc_ext  = 7'(pcnt_q);
	assign pc_out  = (pc_ext > PEAK_COUNT_MAX) ? PEAK_COUNT_MAX[5:0] : pc_ext[5:0];
	assign as_prod = 17'(phasic_q[8:0]) * RECIP_5;
	assign bs_diff = baseline_q - BASE_LOW;
	assign bs_prod = 18'(bs_diff[9:0]) * RECIP_10;
	assign w_prod  = 27'(w_q) * RECIP_100;
	assign w_div   = w_prod[26:19];

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q   <= '0;
			base_valid_q <= 1'b0;
			for (int i = 0; i < LOOKBACK; i++)
				recent_q[i] <= '0;
			scount_q     <= '0;
			win_q        <= '0;
			pcnt_q       <= '0;
			for (int i = 0; i < AMPLITUDE_SLOTS; i++)
				amp_q[i] <= '0;
			slot_q       <= '0;
			amp_sum_q    <= '0;
			amp_cnt_q    <= '0;
			last_q       <= '0;
			mean_q       <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					baseline_q   <= '0;
					base_valid_q <= 1'b0;
					for (int i = 0; i < LOOKBACK; i++)
						recent_q[i] <= '0;
					scount_q     <= '0;
					win_q        <= '0;
					pcnt_q       <= '0;
					for (int i = 0; i < AMPLITUDE_SLOTS; i++)
						amp_q[i] <= '0;
					slot_q       <= '0;
					amp_sum_q    <= '0;
					amp_cnt_q    <= '0;
					last_q       <= '0;
					mean_q       <= '0;
				end
				ST_SEED: begin
					baseline_q   <= x_q;
					base_valid_q <= 1'b1;
				end
				ST_EVAL: begin
					baseline_q <= b_new;
					scount_q   <= scount_n;
					for (int i = LOOKBACK - 1; i > 0; i--)
						recent_q[i] <= recent_q[i-1];
					recent_q[0] <= x_q;
					win_q  <= {win_q[PEAK_WINDOW-2:0], is_peak};
					pcnt_q <= pcnt_q + PC_W'(is_peak) - PC_W'(win_q[PEAK_WINDOW-1]);
					if (is_peak) begin
						last_q          <= t_q;
						amp_q[slot_sel] <= phasic;
						slot_q          <= slot_nxt;
					end
					amp_sum_q <= amp_sum_n;
					amp_cnt_q <= amp_cnt_n;
					if (amp_cnt_n == '0)
						mean_q <= '0;
				end
				ST_MEAN: mean_q <= div_quo_q[14:0];
				default: ;
			endcase
		end
	end

	// per-sample working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= s_tdata[15:0];
			t_q <= s_tdata[47:16];
		end
		case (state_q)
			ST_CLEAR, ST_SEED: begin
				phasic_q <= '0;
				ready_q  <= 1'b0;
				w_q      <= '0;
			end
			ST_EVAL: begin
				phasic_q <= phasic;
				ready_q  <= scount_n >= CNT_W'(READY_SAMPLES);
			end
			ST_SCORE: begin
				fs_q <= (pc_out > FREQ_FULL) ? SCORE_MAX : 7'(7'(pc_out) * FREQ_STEP);
				as_q <= (16'(phasic_q) > AMP_FULL) ? SCORE_MAX : as_prod[16:10];
				if (baseline_q > BASE_HIGH)
					bs_q <= SCORE_MAX;
				else if (baseline_q > BASE_LOW)
					bs_q <= bs_prod[17:11];
				else
					bs_q <= '0;
			end
			ST_WEIGH: begin
				w_q <= 14'(fs_q) * FREQ_WEIGHT + 14'(as_q) * AMP_WEIGHT
					+ 14'(bs_q) * BASE_WEIGHT;
			end
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_stress_q <= ({1'b0, w_div[6:0]} > 8'(SCORE_MAX) || w_div[7]) ?
				SCORE_MAX : w_div[6:0];
			o_tonic_q  <= baseline_q;
			o_phasic_q <= phasic_q;
			o_pc_q     <= pc_out;
			o_mean_q   <= mean_q;
			o_stamp_q  <= last_q;
			o_ready_q  <= ready_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, o_stamp_q, o_mean_q, o_pc_q, o_phasic_q, o_tonic_q, o_stress_q};
	assign m_tuser  = o_ready_q;

endmodule

@@ design/scsi_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsi_chk: port checks of the skin conductance stress index
// Watches the stream ports for sequencer occupancy, field ranges and
// output hold under back-pressure.
// ----------------------------------------------------------------------------
module scsi_chk #(
	parameter int PEAK_WINDOW = scsi_pkg::PEAK_WINDOW_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [scsi_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            m_tuser
);
	import scsi_pkg::*;

	// one word at a time: busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in progress");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:0] <= SCORE_MAX)
		else $error("stress level above full scale");

	a_peak_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, m_tdata[43:38]} <= 7'(PEAK_WINDOW))
		else $error("peak count above window length");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

endmodule

bind skin_conductance_stress_index scsi_chk #(.PEAK_WINDOW(PEAK_WINDOW)) u_scsi_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
